@@ hw/rtl/modexp_pkg.sv @@
// Register map and reset constants for the modular exponentiation block.
package modexp_pkg;

  localparam int unsigned RegIdxW = 1;

  localparam logic [RegIdxW-1:0] REG_EXPONENT = 1'b0;
  localparam logic [RegIdxW-1:0] REG_MODULUS  = 1'b1;

  localparam logic [31:0] EXP_RESET = 32'd7;
  localparam logic [31:0] MOD_RESET = 32'd611;

  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

endpackage

@@ hw/rtl/modular_exponentiation.sv @@
// Modular exponentiation core: right-to-left square and multiply, bit-serial modmul.
//
// Usage: write exponent (address 0) and modulus (address 4) over the APB port
// while idle; reset leaves exponent 7 and modulus 611. Pulse start with base_i
// while busy is low; the item is taken at that edge and busy rises.
// One result appears on power_o with done_o high for exactly one cycle; the
// receiver cannot stall, so no output backpressure exists.
// Sequence: every modular multiply runs on one shared shift-and-subtract unit,
// one multiplier bit per cycle. An item first reduces the base, then for each
// significant exponent bit passes a check state, multiplies the accumulator by
// the square for a one bit and then squares; a final check delivers the result.
// A modulus below two answers 0 in the cycle after start and busy stays low.
// Reset aborts any item in flight and drops busy and done_o.
module modular_exponentiation #(
  parameter int unsigned WORD_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [modexp_pkg::ApbAddrW-1:0]        paddr,
  input  logic [modexp_pkg::ApbDataW-1:0]        pwdata,
  output logic [modexp_pkg::ApbDataW-1:0]        prdata,
  output logic                                   pready,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [WORD_BITS-1:0]                   base_i,
  output logic [WORD_BITS-1:0]                   power_o,
  output logic                                   done_o
);

  localparam int unsigned CntW = $clog2(WORD_BITS);
  localparam logic [CntW-1:0] CntLast = CntW'(WORD_BITS - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_ACC    = 3'd3;
  localparam logic [2:0] ST_SQR    = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [WORD_BITS-1:0]  exponent_q, exponent_d;
  logic [WORD_BITS-1:0]  modulus_q, modulus_d;
  logic                  done_q, done_d;
  logic [WORD_BITS-1:0]  power_q, power_d;
  logic [WORD_BITS-1:0]  acc_q, acc_d;
  logic [WORD_BITS-1:0]  sq_q, sq_d;
  logic [WORD_BITS-1:0]  exp_sh_q, exp_sh_d;
  logic [WORD_BITS-1:0]  mul_a_q, mul_a_d;
  logic [WORD_BITS-1:0]  mul_b_q, mul_b_d;
  logic [WORD_BITS-1:0]  mul_r_q, mul_r_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  logic                  cfg_wr;
  logic [WORD_BITS:0]    dbl;
  logic [WORD_BITS:0]    dbl_red;
  logic [WORD_BITS:0]    sum;
  logic [WORD_BITS:0]    sum_red;
  logic [WORD_BITS-1:0]  r_next;
  logic                  mul_last;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (paddr[2])
      modexp_pkg::REG_EXPONENT: prdata[WORD_BITS-1:0] = exponent_q;
      modexp_pkg::REG_MODULUS:  prdata[WORD_BITS-1:0] = modulus_q;
      default:                  prdata = '0;
    endcase
  end

  always_comb begin
    exponent_d = exponent_q;
    modulus_d  = modulus_q;
    if (cfg_wr) begin
      case (paddr[2])
        modexp_pkg::REG_EXPONENT: exponent_d = pwdata[WORD_BITS-1:0];
        modexp_pkg::REG_MODULUS:  modulus_d  = pwdata[WORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // one interleaved modmul step: r = 2r + a_bit*b mod m
  always_comb begin
    dbl     = {mul_r_q, 1'b0};
    dbl_red = (dbl >= {1'b0, modulus_q}) ? dbl - {1'b0, modulus_q} : dbl;
    sum     = {1'b0, dbl_red[WORD_BITS-1:0]}
              + (mul_a_q[WORD_BITS-1] ? {1'b0, mul_b_q} : '0);
    sum_red = (sum >= {1'b0, modulus_q}) ? sum - {1'b0, modulus_q} : sum;
    r_next  = sum_red[WORD_BITS-1:0];
  end

  assign mul_last = (cnt_q == '0);

  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    power_d  = power_q;
    acc_d    = acc_q;
    sq_d     = sq_q;
    exp_sh_d = exp_sh_q;
    mul_a_d  = {mul_a_q[WORD_BITS-2:0], 1'b0};
    mul_b_d  = mul_b_q;
    mul_r_d  = r_next;
    cnt_d    = cnt_q - 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (modulus_q < WORD_BITS'(2)) begin
            power_d = '0;
            done_d  = 1'b1;
          end else begin
            acc_d    = WORD_BITS'(1);
            exp_sh_d = exponent_q;
            mul_a_d  = base_i;
            mul_b_d  = WORD_BITS'(1);
            mul_r_d  = '0;
            cnt_d    = CntLast;
            state_d  = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mul_last) begin
          sq_d    = r_next;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        mul_r_d = '0;
        cnt_d   = CntLast;
        if (exp_sh_q == '0) begin
          power_d = acc_q;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else if (exp_sh_q[0]) begin
          mul_a_d = acc_q;
          mul_b_d = sq_q;
          state_d = ST_ACC;
        end else begin
          mul_a_d = sq_q;
          mul_b_d = sq_q;
          state_d = ST_SQR;
        end
      end
      ST_ACC: begin
        if (mul_last) begin
          acc_d   = r_next;
          mul_a_d = sq_q;
          mul_b_d = sq_q;
          mul_r_d = '0;
          cnt_d   = CntLast;
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        if (mul_last) begin
          sq_d     = r_next;
          exp_sh_d = exp_sh_q >> 1;
          state_d  = ST_CHECK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      done_q     <= 1'b0;
      exponent_q <= modexp_pkg::EXP_RESET[WORD_BITS-1:0];
      modulus_q  <= modexp_pkg::MOD_RESET[WORD_BITS-1:0];
    end else begin
      state_q    <= state_d;
      done_q     <= done_d;
      exponent_q <= exponent_d;
      modulus_q  <= modulus_d;
    end
  end

  always_ff @(posedge clk_i) begin
    power_q  <= power_d;
    acc_q    <= acc_d;
    sq_q     <= sq_d;
    exp_sh_q <= exp_sh_d;
    mul_a_q  <= mul_a_d;
    mul_b_q  <= mul_b_d;
    mul_r_q  <= mul_r_d;
    cnt_q    <= cnt_d;
  end

  assign busy    = (state_q != ST_IDLE);
  assign done_o  = done_q;
  assign power_o = power_q;

endmodule
